// ===== hw/rtl/sp2p_pkg.sv =====
// Package for the scan polar-to-pixel converter.
// Holds the CORDIC constants, the stage record type and the register indexes.
// No dependencies.
`default_nettype none

package sp2p_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_W     = 18;
  localparam int ANGLE_W      = 16;
  localparam int RANGE_W      = 16;
  localparam int BEAM_W       = 10;
  localparam int SCALE_W      = 8;
  localparam int RS_W         = RANGE_W + SCALE_W;
  localparam int MAG_W        = CORDIC_W - 1;
  localparam int PROD_W       = RS_W + MAG_W;
  localparam int FRAC_SHIFT   = 23;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 18'sd19898;

  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_METER = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd40;

  localparam int IMG_W_DEF     = 400;
  localparam int IMG_H_DEF     = 600;
  localparam int MAX_BEAMS_DEF = 1024;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic                       flip;
    logic [RS_W-1:0]            rs;
    logic                       oob;
    logic                       last;
  } cordic_t;

  function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int step);
    logic signed [CORDIC_W-1:0] a;
    unique case (step)
      0:       a = 18'sd8192;
      1:       a = 18'sd4836;
      2:       a = 18'sd2555;
      3:       a = 18'sd1297;
      4:       a = 18'sd651;
      5:       a = 18'sd326;
      6:       a = 18'sd163;
      7:       a = 18'sd81;
      8:       a = 18'sd41;
      9:       a = 18'sd20;
      10:      a = 18'sd10;
      11:      a = 18'sd5;
      12:      a = 18'sd3;
      13:      a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sp2p_cordic_cell.sv =====
// One rotation step of the CORDIC chain, with its own pipeline register.
// Depends on sp2p_pkg.
`default_nettype none

module sp2p_cordic_cell
  import sp2p_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire cordic_t in_item,
  output logic         out_valid,
  output cordic_t      out_item
);

  localparam logic signed [CORDIC_W-1:0] ATAN = cordic_atan(SHIFT);

  logic signed [CORDIC_W-1:0] x_in;
  logic signed [CORDIC_W-1:0] y_in;
  logic signed [CORDIC_W-1:0] z_in;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  cordic_t                    item_next;

  assign x_in = in_item.x;
  assign y_in = in_item.y;
  assign z_in = in_item.z;
  assign xs   = x_in >>> SHIFT;
  assign ys   = y_in >>> SHIFT;

  always_comb begin
    item_next = in_item;
    if (!z_in[CORDIC_W-1]) begin
      item_next.x = x_in - ys;
      item_next.y = y_in + xs;
      item_next.z = z_in - ATAN;
    end else begin
      item_next.x = x_in + ys;
      item_next.y = y_in - xs;
      item_next.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sp2p_place.sv =====
// Scales sine and cosine by range and pixel scale, offsets them from the
// image center and checks the image bounds. Three pipeline stages.
// Depends on sp2p_pkg.
`default_nettype none

module sp2p_place
  import sp2p_pkg::*;
#(
  parameter int IMG_W = IMG_W_DEF,
  parameter int IMG_H = IMG_H_DEF,
  parameter int COL_W = $clog2(IMG_W),
  parameter int ROW_W = $clog2(IMG_H)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire cordic_t          in_item,
  output logic                  out_valid,
  output logic [COL_W-1:0]      col,
  output logic [ROW_W-1:0]      row,
  output logic                  hit,
  output logic                  last
);

  localparam int OFF_W = PROD_W - FRAC_SHIFT;
  localparam int POS_W = OFF_W + 2;
  localparam logic signed [POS_W-1:0] CENTER_COL = POS_W'(IMG_W / 2);
  localparam logic signed [POS_W-1:0] CENTER_ROW = POS_W'(IMG_H / 2);
  localparam logic signed [POS_W-1:0] LIMIT_COL  = POS_W'(IMG_W);
  localparam logic signed [POS_W-1:0] LIMIT_ROW  = POS_W'(IMG_H);

  logic                       v1;
  logic                       v2;
  logic                       sin_neg1;
  logic                       cos_neg1;
  logic [MAG_W-1:0]           sin_mag1;
  logic [MAG_W-1:0]           cos_mag1;
  logic [RS_W-1:0]            rs1;
  logic                       oob1;
  logic                       last1;
  logic                       sin_neg2;
  logic                       cos_neg2;
  logic [PROD_W-1:0]          sin_prod2;
  logic [PROD_W-1:0]          cos_prod2;
  logic                       oob2;
  logic                       last2;
  logic signed [CORDIC_W-1:0] y_abs;
  logic signed [CORDIC_W-1:0] x_abs;
  logic [OFF_W-1:0]           dx;
  logic [OFF_W-1:0]           dy;
  logic signed [POS_W-1:0]    col_pos;
  logic signed [POS_W-1:0]    row_pos;
  logic                       hit_next;

  assign y_abs = in_item.y[CORDIC_W-1] ? -in_item.y : in_item.y;
  assign x_abs = in_item.x[CORDIC_W-1] ? -in_item.x : in_item.x;

  assign dx = sin_prod2[PROD_W-1:FRAC_SHIFT];
  assign dy = cos_prod2[PROD_W-1:FRAC_SHIFT];

  always_comb begin
    col_pos = sin_neg2 ? CENTER_COL + POS_W'(dx) : CENTER_COL - POS_W'(dx);
    row_pos = cos_neg2 ? CENTER_ROW + POS_W'(dy) : CENTER_ROW - POS_W'(dy);
    hit_next = !oob2 && (col_pos > 0) && (col_pos < LIMIT_COL)
               && (row_pos > 0) && (row_pos < LIMIT_ROW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_neg1  <= in_item.y[CORDIC_W-1] ^ in_item.flip;
      cos_neg1  <= in_item.x[CORDIC_W-1] ^ in_item.flip;
      sin_mag1  <= y_abs[MAG_W-1:0];
      cos_mag1  <= x_abs[MAG_W-1:0];
      rs1       <= in_item.rs;
      oob1      <= in_item.oob;
      last1     <= in_item.last;

      sin_neg2  <= sin_neg1;
      cos_neg2  <= cos_neg1;
      sin_prod2 <= PROD_W'(rs1) * PROD_W'(sin_mag1);
      cos_prod2 <= PROD_W'(rs1) * PROD_W'(cos_mag1);
      oob2      <= oob1;
      last2     <= last1;

      hit  <= hit_next;
      col  <= hit_next ? col_pos[COL_W-1:0] : '0;
      row  <= hit_next ? row_pos[ROW_W-1:0] : '0;
      last <= last2;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/scan_polar_to_pixel.sv =====
// Top level of the scan polar-to-pixel converter: beam angle stage,
// CORDIC cell chain and placement stages. Depends on sp2p_pkg,
// sp2p_cordic_cell and sp2p_place.
//
// Usage: each input transaction on s_* carries one range sample and its
// beam index; s_tlast marks the last sample of a scan. Each produces exactly
// one output transaction on m_* with the image column and row, m_tuser set when
// the beam index is below MAX_BEAMS and the point lies strictly inside the image,
// and m_tlast copied through. Registers start_angle, angle_step and pixels_per_meter
// are written through cfg_wr_en, cfg_index and cfg_data; the user must write them
// only while no sample is in flight, as the block itself does not enforce it.
// Throughput is one transaction per cycle while the output is not stalled, through
// one angle and scale stage, fourteen CORDIC cells and three placement stages.
// The whole pipeline advances together, so when m_tready is low with a result
// waiting, s_tready drops and every stage holds its contents. Reset empties the
// pipeline and restores start_angle 0, angle_step 0 and pixels_per_meter 40.
`default_nettype none

module scan_polar_to_pixel
  import sp2p_pkg::*;
#(
  parameter int IMG_W     = IMG_W_DEF,
  parameter int IMG_H     = IMG_H_DEF,
  parameter int MAX_BEAMS = MAX_BEAMS_DEF,
  parameter int COL_W     = $clog2(IMG_W),
  parameter int ROW_W     = $clog2(IMG_H),
  parameter int OUT_DW    = ((COL_W + ROW_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [31:0]           s_tdata,  // range_value, beam_index
  input  wire logic                  s_tlast,  // last_beam
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DW-1:0]          m_tdata,  // pixel_col, pixel_row
  output logic                       m_tuser,  // hit
  output logic                       m_tlast   // last_point
);

  logic [ANGLE_W-1:0]          start_angle;
  logic [ANGLE_W-1:0]          angle_step;
  logic [SCALE_W-1:0]          pixels_per_meter;
  logic                        en;
  logic [RANGE_W-1:0]          range_value;
  logic [BEAM_W-1:0]           beam_index;
  logic [BEAM_W+ANGLE_W-1:0]   beam_prod;
  logic [ANGLE_W-1:0]          angle;
  cordic_t                     seed;
  logic                        chain_valid [0:CORDIC_STEPS];
  cordic_t                     chain_item  [0:CORDIC_STEPS];
  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle      <= '0;
      angle_step       <= '0;
      pixels_per_meter <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_ANGLE:      start_angle      <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_STEP:       angle_step       <= cfg_data[ANGLE_W-1:0];
        REG_PIXELS_PER_METER: pixels_per_meter <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign range_value = s_tdata[RANGE_W-1:0];
  assign beam_index  = s_tdata[RANGE_W+BEAM_W-1:RANGE_W];
  assign beam_prod   = (BEAM_W+ANGLE_W)'(beam_index) * (BEAM_W+ANGLE_W)'(angle_step);
  assign angle       = start_angle + beam_prod[ANGLE_W-1:0];

  // Angles in the left half-plane are turned by half a circle; the flip bit
  // negates sine and cosine afterwards.
  always_comb begin
    seed      = '0;
    seed.x    = CORDIC_GAIN;
    seed.y    = '0;
    seed.z    = {{(CORDIC_W-ANGLE_W+2){angle[ANGLE_W-2]}}, angle[ANGLE_W-3:0]};
    seed.flip = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    seed.rs   = RS_W'(range_value) * RS_W'(pixels_per_meter);
    seed.oob  = 32'(beam_index) >= 32'(MAX_BEAMS);
    seed.last = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      chain_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_item[0] <= seed;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    sp2p_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_valid[i]),
      .in_item  (chain_item[i]),
      .out_valid(chain_valid[i+1]),
      .out_item (chain_item[i+1])
    );
  end

  sp2p_place #(
    .IMG_W(IMG_W),
    .IMG_H(IMG_H),
    .COL_W(COL_W),
    .ROW_W(ROW_W)
  ) u_place (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (chain_valid[CORDIC_STEPS]),
    .in_item  (chain_item[CORDIC_STEPS]),
    .out_valid(m_tvalid),
    .col      (col),
    .row      (row),
    .hit      (m_tuser),
    .last     (m_tlast)
  );

  assign m_tdata = OUT_DW'({row, col});

`ifndef SYNTHESIS
  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (col != '0) && (row != '0)
      && (32'(col) < 32'(IMG_W)) && (32'(row) < 32'(IMG_H)))
    else $error("hit reported for a pixel outside the image");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (col == '0) && (row == '0))
    else $error("miss carries a nonzero pixel");
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(chain_valid[CORDIC_STEPS]) && $stable(chain_valid[0]))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_scan_polar_to_pixel.sv =====
// Testbench for scan_polar_to_pixel: streams range samples, predicts each pixel
// with its own CORDIC and placement model, and checks every output transaction.
// Depends on sp2p_pkg and the scan_polar_to_pixel RTL.
`default_nettype none

module tb_scan_polar_to_pixel
  import sp2p_pkg::*;
;

  localparam int OUT_DW = 24;
  localparam int IMG_W = 400;
  localparam int IMG_H = 600;
  localparam int GAIN_Q15 = 19898;
  localparam int ROT_STEPS = 14;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int ATAN_Q15 [ROT_STEPS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
  };

  typedef struct packed {
    logic [8:0] col;
    logic [9:0] row;
    logic       hit;
    logic       last;
  } pixel_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          value;
    logic [15:0]          rng;
    logic [9:0]           beam;
    logic                 last;
    logic                 known;
    pixel_t               want;
  } plan_row_t;

  localparam pixel_t CENTRE = '{9'd200, 10'd300, 1'b1, 1'b0};
  localparam pixel_t NO_HIT = '0;
  localparam int PLAN_LEN = 23;

  // A range of zero lands on the image center at any angle; full range at
  // the reset scale or above always leaves the image.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd0, 10'd0, 1'b0, 1'b1, CENTRE},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd65535, 10'd0, 1'b0, 1'b1, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd256, 10'd1, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1, 10'd1023, 1'b1, 1'b0, NO_HIT},
    '{ROW_WRITE, REG_ANGLE_STEP, 16'd16384, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd1, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd2, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd3, 1'b1, 1'b0, NO_HIT},
    '{ROW_WRITE, REG_START_ANGLE, 16'd65535, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd1, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd1280, 10'd2, 1'b0, 1'b0, NO_HIT},
    '{ROW_WRITE, REG_PIXELS_PER_METER, 16'd255, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd65535, 10'd5, 1'b0, 1'b1, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd300, 10'd1022, 1'b1, 1'b0, NO_HIT},
    '{ROW_WRITE, REG_PIXELS_PER_METER, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd65535, 10'd1023, 1'b1, 1'b1, CENTRE},
    '{ROW_WRITE, REG_PIXELS_PER_METER, 16'd1, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd65535, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_WRITE, REG_ANGLE_STEP, 16'd65535, 16'd0, 10'd0, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd0, 10'd1023, 1'b1, 1'b1, CENTRE},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd40000, 10'd512, 1'b0, 1'b0, NO_HIT},
    '{ROW_SAMPLE, REG_START_ANGLE, 16'd0, 16'd51200, 10'd341, 1'b1, 1'b0, NO_HIT}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tlast = 1'b0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [OUT_DW-1:0]     m_tdata;
  wire                   m_tuser;
  wire                   m_tlast;

  logic [15:0] start_q = 16'd0;
  logic [15:0] step_q = 16'd0;
  logic [7:0]  ppm_q = 8'd40;
  pixel_t      pixel_queue [$];
  int          err_count = 0;
  int          sent_total = 0;
  bit          sender_quiet = 1'b0;
  bit          sink_quiet = 1'b0;

  scan_polar_to_pixel dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  function automatic logic [15:0] beam_angle(input logic [9:0] beam);
    return 16'(start_q + beam * step_q);
  endfunction

  function automatic void beam_sin_cos(input logic [15:0] angle, output int sn,
                                       output int cs);
    logic [15:0] a;
    int          x, y, z, xs, ys;
    bit          flip;
    a = angle;
    flip = 1'b0;
    if (a >= 16'd16384 && a < 16'd49152) begin
      a = a - 16'd32768;
      flip = 1'b1;
    end
    z = a[15] ? int'(a) - 65536 : int'(a);
    x = GAIN_Q15;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q15[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q15[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint scale_offset(input logic [15:0] rng, input logic [7:0] ppm,
                                          input int trig);
    longint mag, prod;
    mag = (trig < 0) ? -longint'(trig) : longint'(trig);
    prod = (longint'(rng) * longint'(ppm) * mag) >>> 23;
    return (trig < 0) ? -prod : prod;
  endfunction

  function automatic pixel_t place_point(input logic [15:0] rng, input logic [9:0] beam,
                                         input logic last);
    int     sn, cs;
    longint col, row;
    pixel_t p;
    beam_sin_cos(beam_angle(beam), sn, cs);
    col = IMG_W / 2 - scale_offset(rng, ppm_q, sn);
    row = IMG_H / 2 - scale_offset(rng, ppm_q, cs);
    p = '0;
    p.last = last;
    if (col > 0 && col < IMG_W && row > 0 && row < IMG_H) begin
      p.col = col[8:0];
      p.row = row[9:0];
      p.hit = 1'b1;
    end
    return p;
  endfunction

  // Picks a range near an image border; a random one if the trig or scale is zero.
  function automatic logic [15:0] border_range(input logic [9:0] beam);
    int     sn, cs, trig, target, jitter;
    longint r;
    beam_sin_cos(beam_angle(beam), sn, cs);
    if ($urandom_range(0, 1) == 1) begin
      trig = sn;
      target = IMG_W / 2;
    end else begin
      trig = cs;
      target = IMG_H / 2;
    end
    if (trig < 0) trig = -trig;
    if (trig == 0 || ppm_q == 8'd0) return 16'($urandom);
    jitter = int'($urandom_range(0, 4)) - 2;
    r = (longint'(target) <<< 23) / (longint'(ppm_q) * trig) + jitter;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  task automatic push_sample(input logic [15:0] rng, input logic [9:0] beam,
                             input logic last, input pixel_t want);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {6'd0, beam, rng};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixel_queue.push_back(want);
    sent_total++;
  endtask

  task automatic drain();
    int waited;
    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (pixel_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pixel_queue.size() != 0) begin
      $display("%0d expected pixels never arrived", pixel_queue.size());
      err_count++;
      pixel_queue.delete();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_START_ANGLE:      start_q = value;
      REG_ANGLE_STEP:       step_q = value;
      REG_PIXELS_PER_METER: ppm_q = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] start, input logic [15:0] step,
                          input logic [7:0] ppm);
    drain();
    write_reg(REG_START_ANGLE, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_PIXELS_PER_METER, {8'd0, ppm});
  endtask

  // Mostly whole scans of consecutive beams ending in tlast; now and then a
  // burst of scattered beams with random tlast.
  task automatic run_phase(input int count);
    int          sent, len;
    logic [9:0]  base, beam;
    logic [15:0] rng;
    logic        last;
    bit          noise;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 40);
      base = 10'($urandom);
      noise = ($urandom_range(0, 9) == 0);
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        beam = noise ? 10'($urandom) : base + 10'(k);
        case ($urandom_range(0, 4))
          0, 1:    rng = 16'($urandom);
          2:       rng = border_range(beam);
          default: rng = 16'($urandom_range(0, 3000));
        endcase
        last = noise ? 1'($urandom) : (k == len - 1);
        push_sample(rng, beam, last, place_point(rng, beam, last));
      end
      sent += len;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int     gap, got;
    bit     held, bad;
    pixel_t want, seen;
    got = 0;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (got % 32 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      if (!held && sent_total >= HOLD_AT) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = sink_quiet ? 0 : $urandom_range(0, 9);
      end
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got++;
      seen = '{m_tdata[8:0], m_tdata[18:9], m_tuser, m_tlast};
      if (pixel_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("pixel %0d: unexpected, col %0d row %0d hit %0b last %0b",
                   got, seen.col, seen.row, seen.hit, seen.last);
      end else begin
        want = pixel_queue.pop_front();
        bad = (seen.col != want.col) || (seen.row != want.row) ||
              (seen.hit != want.hit) || (seen.last != want.last);
        if (bad) begin
          err_count++;
          if (err_count <= 10)
            $display("pixel %0d: expected col %0d row %0d hit %0b last %0b, %s",
                     got, want.col, want.row, want.hit, want.last,
                     $sformatf("got col %0d row %0d hit %0b last %0b",
                               seen.col, seen.row, seen.hit, seen.last));
        end
      end
    end
  end

  initial begin
    pixel_t want;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        drain();
        write_reg(PLAN[i].idx, PLAN[i].value);
      end else begin
        want = PLAN[i].known ? PLAN[i].want
                             : place_point(PLAN[i].rng, PLAN[i].beam, PLAN[i].last);
        want.last = PLAN[i].last;
        push_sample(PLAN[i].rng, PLAN[i].beam, PLAN[i].last, want);
      end
    end

    set_regs(16'($urandom), 16'($urandom), 8'd40);
    run_phase(150);
    set_regs(16'hFFFF, 16'hFFFF, 8'd255);
    run_phase(150);
    set_regs(16'd0, 16'd64, 8'd1);
    run_phase(150);
    set_regs(16'($urandom), 16'd1, 8'($urandom_range(1, 255)));
    run_phase(150);
    set_regs(16'($urandom), 16'($urandom), 8'd0);
    run_phase(40);
    set_regs(16'd0, 16'd0, 8'($urandom_range(1, 255)));
    run_phase(150);
    set_regs(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
    run_phase(150);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
